>>> sv/bankers_safety_check_assert.svh
// assertion macros for the safety check modules (used by bsc_ctrl)
// each macro expects clk and arst_n to be visible where it is used
`ifndef BANKERS_SAFETY_CHECK_ASSERT_SVH
`define BANKERS_SAFETY_CHECK_ASSERT_SVH

// condition holds on every clock out of reset
`define BSC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bsc_pkg.sv
// shared types, sizes and helper functions for the banker's safety check
// no dependencies; imported by every module of the block
package bsc_pkg;

	localparam int MAX_PROCS = 8;
	localparam int MAX_RES   = 4;
	localparam int UNIT_BITS = 8;

	localparam int PROC_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int RES_W     = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int TBL_DEPTH = MAX_PROCS * MAX_RES;
	localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int SUM_W     = UNIT_BITS + PROC_W;

	// fixed port field widths
	localparam int FIELD_W   = 8;
	localparam int MASK_W    = 8;
	localparam int NP_W      = 4;
	localparam int NR_W      = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 4;

	typedef logic [UNIT_BITS-1:0] unit_t;
	typedef logic [PROC_W-1:0]    proc_t;
	typedef logic [RES_W-1:0]     res_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [MAX_PROCS-1:0] done_t;

	typedef enum logic [1:0] {
		OP_LOAD_TOTAL = 2'd0,
		OP_LOAD_PROC  = 2'd1,
		OP_CHECK      = 2'd2
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_PROCS = 1'd0,
		CFG_NUM_RES   = 1'd1
	} cfg_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_SUM_WAIT,
		ST_EVAL,
		ST_READ,
		ST_WAIT,
		ST_DECIDE
	} state_e;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [2:0]         proc_index;
		logic [1:0]         res_index;
		logic [FIELD_W-1:0] max_units;
		logic [FIELD_W-1:0] alloc_units;
		logic [FIELD_W-1:0] total_units;
	} cmd_t;

	typedef struct packed {
		logic              safe;
		logic [MASK_W-1:0] finished_mask;
		logic              invalid;
	} rsp_t;

	typedef struct packed {
		unit_t max_u;
		unit_t alloc_u;
	} entry_t;

	typedef struct packed {
		logic   en;
		addr_t  addr;
		entry_t data;
	} tbl_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} tbl_rd_t;

	typedef struct packed {
		proc_t last_proc;
		res_t  last_res;
	} limits_t;

	function automatic unit_t to_unit(logic [FIELD_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[UNIT_BITS-1:0];
	endfunction

	function automatic logic [MASK_W-1:0] to_mask(done_t d);
		logic [31:0] w;
		w = 32'(d);
		return w[MASK_W-1:0];
	endfunction

	function automatic addr_t tbl_addr(proc_t p, res_t r);
		return ADDR_W'(int'(p) * MAX_RES + int'(r));
	endfunction

	// zero counts as one, anything above the maximum counts as the maximum
	function automatic proc_t last_proc_of(logic [NP_W-1:0] v);
		int n;
		n = (v == '0) ? 1 : ((int'(v) > MAX_PROCS) ? MAX_PROCS : int'(v));
		return PROC_W'(n - 1);
	endfunction

	function automatic res_t last_res_of(logic [NR_W-1:0] v);
		int n;
		n = (v == '0) ? 1 : ((int'(v) > MAX_RES) ? MAX_RES : int'(v));
		return RES_W'(n - 1);
	endfunction

endpackage

>>> sv/bsc_table_store.sv
// max / alloc table: one synchronous ram, one write and one read port
// valid bit per entry so unwritten entries read as zero; uses bsc_pkg
module bsc_table_store import bsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  tbl_wr_t wr,
	input  tbl_rd_t rd,
	output entry_t  rd_data
);

	entry_t              mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] vld_q;
	entry_t              rd_q;
	logic                hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_q  <= mem[rd.addr];
			hit_q <= vld_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data = hit_q ? rd_q : '0;

endmodule

>>> sv/bsc_ctrl.sv
// check sequencer: load decode, allocation sums, safety passes, result
// uses bsc_pkg and the assertion macros; drives bsc_table_store
`include "bankers_safety_check_assert.svh"

module bsc_ctrl import bsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	input  limits_t lim,
	output logic    busy,
	output tbl_wr_t tbl_wr,
	output tbl_rd_t tbl_rd,
	input  entry_t  rd_data,
	output rsp_t    result,
	output logic    strobe
);

	state_e state_q, state_d;
	proc_t  p_q, pass_q;
	res_t   r_q, r_s1;
	logic   rd_vld_s1, sum_s1;
	done_t  done_q, done_nx, all_m;
	logic   fits_q, prog_q, bad_q;
	sum_t   sum_q [MAX_RES];
	unit_t  work_q [MAX_RES];
	unit_t  alloc_buf_q [MAX_RES];
	unit_t  total_q [MAX_RES];
	rsp_t   rsp_q;
	logic   strobe_q;

	logic   rd_en, wr_en;
	logic   ld_proc_ok, ld_res_ok;
	logic   fin_now, proc_end, chk_end, bad_now, over;
	unit_t  need_s1;

	assign busy       = (state_q != ST_IDLE);
	assign ld_proc_ok = (32'(cmd.proc_index) < MAX_PROCS);
	assign ld_res_ok  = (32'(cmd.res_index) < MAX_RES);
	assign need_s1    = rd_data.max_u - rd_data.alloc_u;

	always_comb begin
		for (int i = 0; i < MAX_PROCS; i++) begin
			all_m[i] = (i <= int'(lim.last_proc));
		end
		over = 1'b0;
		for (int r = 0; r < MAX_RES; r++) begin
			if ((r <= int'(lim.last_res)) && (sum_q[r] > SUM_W'(total_q[r]))) begin
				over = 1'b1;
			end
		end
	end

	assign bad_now  = bad_q | over;
	assign fin_now  = (state_q == ST_DECIDE) && fits_q;
	assign done_nx  = done_q | (fin_now ? (done_t'(1) << p_q) : '0);
	assign proc_end = (state_q == ST_DECIDE) || ((state_q == ST_READ) && done_q[p_q]);
	assign chk_end  = proc_end && (p_q == lim.last_proc) &&
		((done_nx == all_m) || (pass_q == lim.last_proc) || !(prog_q || fin_now));

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.opcode)
						OP_LOAD_PROC: wr_en   = ld_proc_ok && ld_res_ok;
						OP_CHECK:     state_d = ST_SUM;
						default:      ;
					endcase
				end
			end
			ST_SUM: begin
				rd_en = 1'b1;
				if ((r_q == lim.last_res) && (p_q == lim.last_proc)) begin
					state_d = ST_SUM_WAIT;
				end
			end
			ST_SUM_WAIT: state_d = ST_EVAL;
			ST_EVAL:     state_d = bad_now ? ST_IDLE : ST_READ;
			ST_READ: begin
				if (!done_q[p_q]) begin
					rd_en = 1'b1;
					if (r_q == lim.last_res) begin
						state_d = ST_WAIT;
					end
				end else if (chk_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_WAIT:   state_d = ST_DECIDE;
			ST_DECIDE: state_d = chk_end ? ST_IDLE : ST_READ;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign tbl_rd.en        = rd_en;
	assign tbl_rd.addr      = tbl_addr(p_q, r_q);
	assign tbl_wr.en        = wr_en;
	assign tbl_wr.addr      = tbl_addr(proc_t'(cmd.proc_index), res_t'(cmd.res_index));
	assign tbl_wr.data      = '{max_u: to_unit(cmd.max_units), alloc_u: to_unit(cmd.alloc_units)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			strobe_q  <= ((state_q == ST_EVAL) && bad_now) || chk_end;
		end
	end

	// resource totals start at zero like the tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_RES; r++) begin
				total_q[r] <= '0;
			end
		end else if ((state_q == ST_IDLE) && start && (cmd.opcode == OP_LOAD_TOTAL) &&
			ld_res_ok) begin
			total_q[res_t'(cmd.res_index)] <= to_unit(cmd.total_units);
		end
	end

	always_ff @(posedge clk) begin
		r_s1   <= r_q;
		sum_s1 <= (state_q == ST_SUM);

		// read data returns in the cycle after the address
		if (rd_vld_s1) begin
			if (sum_s1) begin
				sum_q[r_s1] <= sum_q[r_s1] + SUM_W'(rd_data.alloc_u);
				if (rd_data.alloc_u > rd_data.max_u) begin
					bad_q <= 1'b1;
				end
			end else begin
				alloc_buf_q[r_s1] <= rd_data.alloc_u;
				if (need_s1 > work_q[r_s1]) begin
					fits_q <= 1'b0;
				end
			end
		end

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.opcode)
						OP_CHECK: begin
							p_q   <= '0;
							r_q   <= '0;
							bad_q <= 1'b0;
							for (int r = 0; r < MAX_RES; r++) begin
								sum_q[r] <= '0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SUM: begin
				if (r_q == lim.last_res) begin
					r_q <= '0;
					p_q <= (p_q == lim.last_proc) ? '0 : p_q + 1'b1;
				end else begin
					r_q <= r_q + 1'b1;
				end
			end
			ST_EVAL: begin
				done_q <= '0;
				pass_q <= '0;
				p_q    <= '0;
				r_q    <= '0;
				fits_q <= 1'b1;
				prog_q <= 1'b0;
				for (int r = 0; r < MAX_RES; r++) begin
					work_q[r] <= bad_now ? '0 : unit_t'(SUM_W'(total_q[r]) - sum_q[r]);
				end
				if (bad_now) begin
					rsp_q <= '{safe: 1'b0, finished_mask: '0, invalid: 1'b1};
				end
			end
			ST_READ: begin
				if (!done_q[p_q]) begin
					r_q <= (r_q == lim.last_res) ? '0 : r_q + 1'b1;
				end
			end
			ST_DECIDE: begin
				if (fin_now) begin
					done_q[p_q] <= 1'b1;
					prog_q      <= 1'b1;
					for (int r = 0; r < MAX_RES; r++) begin
						if (r <= int'(lim.last_res)) begin
							work_q[r] <= work_q[r] + alloc_buf_q[r];
						end
					end
				end
			end
			default: ;
		endcase

		if (proc_end) begin
			fits_q <= 1'b1;
			r_q    <= '0;
			if (p_q == lim.last_proc) begin
				if (!chk_end) begin
					pass_q <= pass_q + 1'b1;
					p_q    <= '0;
					prog_q <= 1'b0;
				end
			end else begin
				p_q <= p_q + 1'b1;
			end
		end

		if (chk_end) begin
			rsp_q <= '{safe: (done_nx == all_m), finished_mask: to_mask(done_nx), invalid: 1'b0};
		end
	end

	assign result = rsp_q;
	assign strobe = strobe_q;

	`BSC_ASSERT_IMP(a_strobe_idle, strobe_q, state_q == ST_IDLE, "result strobe while busy")
	`BSC_ASSERT_IMP(a_rd_busy, rd_vld_s1, state_q != ST_IDLE, "read data returned while idle")
	`BSC_ASSERT_ALWAYS(a_port_excl, !(tbl_wr.en && tbl_rd.en), "table read and write collide")
	`BSC_ASSERT_NEXT(a_check_start, (state_q == ST_IDLE) && start && (cmd.opcode == OP_CHECK), state_q == ST_SUM, "check did not start")
	`BSC_ASSERT_IMP(a_invalid_rsp, strobe_q && rsp_q.invalid, !rsp_q.safe && (rsp_q.finished_mask == '0), "invalid result not cleared")

endmodule

>>> sv/bankers_safety_check.sv
// banker's safety check: loads are written straight from idle, busy stays low, no result
// check: np*nr table reads sum the allocations, then passes walk the processes; a pass
// skips finished processes and reads the nr entries of each other one, up to np passes;
// the result strobe is registered; the single table ram read port sets the pace
// arst_n clears control state, config to 8 processes / 4 resources, tables to zero
// results cannot be stalled: the strobe marks one cycle with valid result
module bankers_safety_check import bsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	// result channel
	output rsp_t                 result,
	output logic                 strobe,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [NP_W-1:0] num_procs_q;
	logic [NR_W-1:0] num_res_q;
	limits_t         lim;
	tbl_wr_t         tbl_wr;
	tbl_rd_t         tbl_rd;
	entry_t          rd_data;

	// config is always accepted; a transfer lands in the addressed register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_procs_q <= NP_W'(MAX_PROCS);
			num_res_q   <= NR_W'(MAX_RES);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NUM_PROCS: num_procs_q <= cfg_data[NP_W-1:0];
				CFG_NUM_RES:   num_res_q   <= cfg_data[NR_W-1:0];
				default:       ;
			endcase
		end
	end

	// clamp counts: zero acts as one, oversize acts as the table size
	assign lim.last_proc = last_proc_of(num_procs_q);
	assign lim.last_res  = last_res_of(num_res_q);

	// per-process max and alloc units live in one synchronous ram
	bsc_table_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (rd_data)
	);

	// sequencer: decodes commands, sums allocations, walks the passes
	bsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.lim     (lim),
		.busy    (busy),
		.tbl_wr  (tbl_wr),
		.tbl_rd  (tbl_rd),
		.rd_data (rd_data),
		.result  (result),
		.strobe  (strobe)
	);

endmodule
